@@ rtl/rroh_pkg.sv @@
package rroh_pkg;

  // Field widths of the request and result channels
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned COL_W   = 6;
  localparam int unsigned INTER_W = 15;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned SIM_W   = 17;

  // Widest row word the popcount handles
  localparam int unsigned WORD_MAX_W = 64;
  localparam int unsigned PC_W       = 7;

  // Similarity fraction bits (Q1.16)
  localparam int unsigned FRAC_W = 16;

  // Similarity when both regions are empty
  localparam logic [SIM_W-1:0] SIM_ONE = 17'd65536;

  // Opcodes
  localparam logic [OP_W-1:0] OP_RUN_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col_start;
    logic [COL_W-1:0] col_end;
  } in_req_t;

  typedef struct packed {
    logic [INTER_W-1:0] intersection_area;
    logic [DIST_W-1:0]  hamming_distance;
    logic [SIM_W-1:0]   similarity;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RUN,
    ST_WALK,
    ST_TAIL,
    ST_DIV_GO,
    ST_DIV,
    ST_DONE
  } state_t;

  // Population count of a 64-bit word, byte by byte
  function automatic logic [PC_W-1:0] popcount64(input logic [WORD_MAX_W-1:0] w);
    logic [PC_W-1:0] total;
    logic [3:0]      byte_cnt;
    total = '0;
    for (int b = 0; b < WORD_MAX_W / 8; b++) begin
      byte_cnt = '0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt = byte_cnt + 4'(w[b*8+i]);
      end
      total = total + PC_W'(byte_cnt);
    end
    return total;
  endfunction

endpackage

@@ rtl/rroh_ram.sv @@
module rroh_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rroh_div.sv @@
module rroh_div #(
  parameter int unsigned NUM_W = 36,
  parameter int unsigned DEN_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    rem_sh;
  logic              ge;

  // Restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem_r, quo_r[NUM_W-1]};
    ge       = rem_sh >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(NUM_W);
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[NUM_W-2:0], ge};
      rem_nxt  = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ rtl/run_region_overlap_hamming_core.sv @@
// Runs: one request per cycle while in_ready is high; each run is a read-modify-write of one
//   row word, written back the cycle after it is accepted (back-to-back hits are forwarded).
// Finish: the result waits on the one-row-per-cycle walk and the bit-serial divider.
// Reset: a clearing pass writes zero to every row of both planes, with in_ready low
//   until it ends.
module run_region_overlap_hamming_core
  import rroh_pkg::*;
#(
  parameter int unsigned IMAGE_WIDTH  = 64,
  parameter int unsigned IMAGE_HEIGHT = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_req
);

  localparam int unsigned AW    = $clog2(IMAGE_HEIGHT);
  localparam int unsigned CNT_W = $clog2(IMAGE_WIDTH * IMAGE_HEIGHT + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned NUM_W = SUM_W + FRAC_W + 1;

  state_t state_r, state_nxt;

  logic [AW-1:0] row_ctr_r, row_ctr_nxt;
  logic          row_last;

  // Run stage (read data returns here)
  logic                   s1_vld_r, s1_vld_nxt;
  logic                   s1_plane_r, s1_plane_nxt;
  logic [AW-1:0]          s1_addr_r, s1_addr_nxt;
  logic [IMAGE_WIDTH-1:0] s1_mask_r, s1_mask_nxt;

  // Last write, forwarded to a following hit on the same row
  logic                   fw_vld_r;
  logic                   fw_plane_r;
  logic [AW-1:0]          fw_addr_r;
  logic [IMAGE_WIDTH-1:0] fw_data_r;

  // Walk pipeline
  logic            rd_vld_r, rd_vld_nxt;
  logic            pc_vld_r;
  logic [PC_W-1:0] pc_a_r, pc_b_r, pc_i_r;

  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0] cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0] cnt_i_r, cnt_i_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  logic     out_valid_r, out_valid_nxt;
  out_req_t out_req_r, out_req_nxt;

  // RAM ports
  logic [AW-1:0]          raddr;
  logic [IMAGE_WIDTH-1:0] a_rdata, b_rdata;
  logic                   a_we, b_we;
  logic [AW-1:0]          waddr;
  logic [IMAGE_WIDTH-1:0] a_wdata, b_wdata;

  logic                   accept, run_ok, is_run, sweep;
  logic [IMAGE_WIDTH-1:0] run_mask;
  logic [IMAGE_WIDTH-1:0] base_word, merged_word;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;

  rroh_ram #(.WIDTH(IMAGE_WIDTH), .DEPTH(IMAGE_HEIGHT)) u_plane_a (
    .clk  (clk),
    .we   (a_we),
    .waddr(waddr),
    .wdata(a_wdata),
    .raddr(raddr),
    .rdata(a_rdata)
  );

  rroh_ram #(.WIDTH(IMAGE_WIDTH), .DEPTH(IMAGE_HEIGHT)) u_plane_b (
    .clk  (clk),
    .we   (b_we),
    .waddr(waddr),
    .wdata(b_wdata),
    .raddr(raddr),
    .rdata(b_rdata)
  );

  rroh_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (sum_r),
    .done (div_done),
    .quo  (div_quo)
  );

  assign in_ready = (state_r == ST_RUN);
  assign accept   = in_valid && in_ready;
  assign is_run   = (in_req.op == OP_RUN_A) || (in_req.op == OP_RUN_B);
  assign row_last = (row_ctr_r == AW'(IMAGE_HEIGHT - 1));
  assign sweep    = (state_r == ST_CLEAR) || (state_r == ST_WALK);

  // Run decode: row and column range checks, span mask
  always_comb begin
    run_ok = (32'(in_req.row) < 32'(IMAGE_HEIGHT)) &&
             (in_req.col_end >= in_req.col_start) &&
             (32'(in_req.col_start) < 32'(IMAGE_WIDTH));
    for (int i = 0; i < IMAGE_WIDTH; i++) begin
      run_mask[i] = (32'(i) >= 32'(in_req.col_start)) && (32'(i) <= 32'(in_req.col_end));
    end
  end

  // Read address: walk row or incoming run row
  assign raddr = (state_r == ST_WALK) ? row_ctr_r : AW'(in_req.row);

  // Merge with forwarding from the previous write
  always_comb begin
    if (fw_vld_r && (fw_plane_r == s1_plane_r) && (fw_addr_r == s1_addr_r)) begin
      base_word = fw_data_r;
    end else begin
      base_word = s1_plane_r ? b_rdata : a_rdata;
    end
    merged_word = base_word | s1_mask_r;
  end

  // Write ports: zero during clearing and walk, merged row otherwise
  assign a_we    = sweep || (s1_vld_r && !s1_plane_r);
  assign b_we    = sweep || (s1_vld_r && s1_plane_r);
  assign waddr   = sweep ? row_ctr_r : s1_addr_r;
  assign a_wdata = sweep ? '0 : merged_word;
  assign b_wdata = sweep ? '0 : merged_word;

  assign div_num = NUM_W'({cnt_i_r, 1'b0, {FRAC_W{1'b0}}}) + NUM_W'(sum_r >> 1);

  // Control
  always_comb begin
    state_nxt     = state_r;
    row_ctr_nxt   = row_ctr_r;
    s1_vld_nxt    = 1'b0;
    s1_plane_nxt  = (in_req.op == OP_RUN_B);
    s1_addr_nxt   = AW'(in_req.row);
    s1_mask_nxt   = run_mask;
    rd_vld_nxt    = 1'b0;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    cnt_i_nxt     = cnt_i_r;
    sum_nxt       = sum_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_req_nxt   = out_req_r;

    if (pc_vld_r) begin
      cnt_a_nxt = cnt_a_r + CNT_W'(pc_a_r);
      cnt_b_nxt = cnt_b_r + CNT_W'(pc_b_r);
      cnt_i_nxt = cnt_i_r + CNT_W'(pc_i_r);
    end

    case (state_r)
      ST_CLEAR: begin
        row_ctr_nxt = row_ctr_r + AW'(1);
        if (row_last) begin
          row_ctr_nxt = '0;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept && is_run) begin
          s1_vld_nxt = run_ok;
        end else if (accept && (in_req.op == OP_FINISH)) begin
          cnt_a_nxt   = '0;
          cnt_b_nxt   = '0;
          cnt_i_nxt   = '0;
          row_ctr_nxt = '0;
          state_nxt   = ST_WALK;
        end
      end
      ST_WALK: begin
        rd_vld_nxt  = 1'b1;
        row_ctr_nxt = row_ctr_r + AW'(1);
        if (row_last) begin
          row_ctr_nxt = '0;
          state_nxt   = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (!rd_vld_r && !pc_vld_r) begin
          sum_nxt   = SUM_W'(cnt_a_r) + SUM_W'(cnt_b_r);
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                 = 1'b1;
          out_req_nxt.intersection_area = INTER_W'(cnt_i_r);
          out_req_nxt.hamming_distance  = DIST_W'(sum_r - {cnt_i_r, 1'b0});
          out_req_nxt.similarity        = (sum_r == '0) ? SIM_ONE : SIM_W'(div_quo);
          state_nxt                     = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      row_ctr_r   <= '0;
      s1_vld_r    <= 1'b0;
      fw_vld_r    <= 1'b0;
      rd_vld_r    <= 1'b0;
      pc_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      cnt_i_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      row_ctr_r   <= row_ctr_nxt;
      s1_vld_r    <= s1_vld_nxt;
      fw_vld_r    <= s1_vld_r;
      rd_vld_r    <= rd_vld_nxt;
      pc_vld_r    <= rd_vld_r;
      out_valid_r <= out_valid_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      cnt_i_r     <= cnt_i_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_plane_r <= s1_plane_nxt;
    s1_addr_r  <= s1_addr_nxt;
    s1_mask_r  <= s1_mask_nxt;
    fw_plane_r <= s1_plane_r;
    fw_addr_r  <= s1_addr_r;
    fw_data_r  <= merged_word;
    pc_a_r     <= popcount64(WORD_MAX_W'(a_rdata));
    pc_b_r     <= popcount64(WORD_MAX_W'(b_rdata));
    pc_i_r     <= popcount64(WORD_MAX_W'(a_rdata & b_rdata));
    sum_r      <= sum_nxt;
    out_req_r  <= out_req_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule
